FILE: hw/rtl/dvrt_pkg.sv
package dvrt_pkg;

  localparam logic [31:0] MASK_A = 32'hff000000;
  localparam logic [31:0] MASK_B = 32'hffff0000;
  localparam logic [31:0] MASK_C = 32'hffffff00;
  localparam logic [4:0]  UNREACHABLE = 5'd16;
  localparam logic [4:0]  METRIC_ONE = 5'd1;

  typedef enum logic [2:0] {
    ACT_UPDATE = 3'd0,
    ACT_QUERY  = 3'd1,
    ACT_DUMP   = 3'd2,
    ACT_TICK   = 3'd3,
    ACT_ADV    = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    ST_ADDED    = 3'd0,
    ST_REPLACED = 3'd1,
    ST_IGNORED  = 3'd2,
    ST_FULL     = 3'd3,
    ST_HIT      = 3'd4,
    ST_MISS     = 3'd5,
    ST_ENTRY    = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    CFG_IFACE0  = 3'd0,
    CFG_IFACE1  = 3'd1,
    CFG_IFACE2  = 3'd2,
    CFG_IFACE3  = 3'd3,
    CFG_ICOUNT  = 3'd4,
    CFG_FAR     = 3'd5,
    CFG_DISCARD = 3'd6,
    CFG_HORIZON = 3'd7
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SLOTS,
    S_IFACES,
    S_DECIDE,
    S_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the input word, clear scan state
    logic slot_step;  // process the slot under the scan index
    logic if_step;    // process the interface under the interface index
    logic decide;     // finish an update, query, dump or advertise, build the final word
    logic pop;        // output word taken
  } dvrt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic slot_done;  // scan index on the last slot
    logic if_done;    // no interface left to visit
    logic emit;       // a word is waiting in the output register
    logic act_tick;
    logic act_bad;
    logic act_emit;   // dump or advertise
  } dvrt_sts_t;

  function automatic logic [31:0] class_net(input logic [31:0] a);
    logic [31:0] r;
    if (!a[31]) r = a & MASK_A;
    else if (a[31:30] == 2'b10) r = a & MASK_B;
    else if (a[31:29] == 3'b110) r = a & MASK_C;
    else r = a;
    return r;
  endfunction

  function automatic logic [4:0] plus_one(input logic [4:0] m);
    return (m >= UNREACHABLE - 5'd1) ? UNREACHABLE : m + 5'd1;
  endfunction

endpackage

FILE: hw/rtl/distance_vector_route_table_top.sv
// Distance-vector route table with classful network matching. Each input
// word is processed sequentially: an accept step, a scan of every table
// slot (one slot per cycle while the output is not stalled), then the in-use
// interfaces (one per cycle, likewise while the output is not stalled), a
// decision step and a wait for the final word to leave. A tick ends after the
// slot scan and an unknown action right after the accept step; neither sends
// a word. Dump and advertise words carry entries, each held back by one word
// so that last lands on the final entry; only when nothing was sent does a
// single status-entry word with entry_valid low close the item. The final
// word of every update, query, dump or advertise has last set.
module distance_vector_route_table_top import dvrt_pkg::*; #(
  parameter int TABLE_DEPTH = 16,
  parameter int MAX_IFACES = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_action,
  input  logic [31:0] in_dest_addr,
  input  logic [4:0]  in_metric_in,
  input  logic [31:0] in_sender_addr,
  input  logic [31:0] in_port_addr,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [31:0] out_net_addr,
  output logic [4:0]  out_metric,
  output logic        out_entry_valid,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  dvrt_cmd_t cmd;
  dvrt_sts_t sts;

  // Configuration words are always taken.
  assign cfg_ready = 1'b1;

  dvrt_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_ready, .sts, .cmd
  );

  dvrt_datapath #(.TABLE_DEPTH(TABLE_DEPTH), .MAX_IFACES(MAX_IFACES)) u_dp (
    .clk, .rst_n, .cmd, .sts,
    .in_action, .in_dest_addr, .in_metric_in, .in_sender_addr, .in_port_addr,
    .cfg_valid, .cfg_index, .cfg_data,
    .out_valid, .out_status, .out_net_addr, .out_metric, .out_entry_valid,
    .out_last
  );

endmodule

FILE: hw/rtl/dvrt_ctrl.sv
module dvrt_ctrl import dvrt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      out_ready,
  input  dvrt_sts_t sts,
  output dvrt_cmd_t cmd
);

  state_t state_r, state_nxt;

  // The output register holds one word; each scan or decision step holds in
  // its state while a word is still waiting and not being taken. S_OUT
  // waits for the final word of the item.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_SLOTS;
      S_SLOTS: begin
        if (sts.act_bad) state_nxt = S_IDLE;
        else if (sts.slot_done) state_nxt = sts.act_tick ? S_IDLE : S_IFACES;
      end
      S_IFACES: if (sts.if_done) state_nxt = S_DECIDE;
      S_DECIDE: state_nxt = S_OUT;
      S_OUT:    if (!sts.emit || out_ready) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_SLOTS:  cmd.slot_step = !sts.act_bad && (!sts.emit || out_ready);
      S_IFACES: cmd.if_step = !sts.if_done && (!sts.emit || out_ready);
      S_DECIDE: cmd.decide = !sts.emit || out_ready;
      S_OUT:    cmd.pop = sts.emit && out_ready;
      default: ;
    endcase
    if (sts.emit && out_ready && state_r != S_OUT) cmd.pop = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else if (state_r == S_SLOTS && sts.emit && !out_ready) state_r <= S_SLOTS;
    else if (state_r == S_IFACES && sts.emit && !out_ready) state_r <= S_IFACES;
    else if (state_r == S_DECIDE && sts.emit && !out_ready) state_r <= S_DECIDE;
    else state_r <= state_nxt;
  end

  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> state_r == S_IDLE) else $error("ready outside idle");
  a_load_next: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> state_r == S_SLOTS) else $error("load lost");
  a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({cmd.load, cmd.slot_step, cmd.if_step, cmd.decide}) <= 1)
    else $error("two commands");

endmodule

FILE: hw/rtl/dvrt_datapath.sv
module dvrt_datapath import dvrt_pkg::*; #(
  parameter int TABLE_DEPTH = 16,
  parameter int MAX_IFACES = 4,
  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic        clk,
  input  logic        rst_n,
  input  dvrt_cmd_t   cmd,
  output dvrt_sts_t   sts,
  input  logic [2:0]  in_action,
  input  logic [31:0] in_dest_addr,
  input  logic [4:0]  in_metric_in,
  input  logic [31:0] in_sender_addr,
  input  logic [31:0] in_port_addr,
  input  logic        cfg_valid,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [31:0] out_net_addr,
  output logic [4:0]  out_metric,
  output logic        out_entry_valid,
  output logic        out_last
);

  // Configuration.
  logic [31:0] iface_r [4];
  logic [2:0]  icount_r;
  logic [7:0]  far_r, discard_r;
  logic [1:0]  horizon_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 4; k++) iface_r[k] <= '0;
      icount_r <= '0;
      far_r <= 8'd6;
      discard_r <= 8'd10;
      horizon_r <= 2'd1;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_IFACE0:  iface_r[0] <= cfg_data;
        CFG_IFACE1:  iface_r[1] <= cfg_data;
        CFG_IFACE2:  iface_r[2] <= cfg_data;
        CFG_IFACE3:  iface_r[3] <= cfg_data;
        CFG_ICOUNT:  icount_r <= cfg_data[2:0];
        CFG_FAR:     far_r <= cfg_data[7:0];
        CFG_DISCARD: discard_r <= cfg_data[7:0];
        CFG_HORIZON: horizon_r <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  localparam logic [2:0] MAXI = 3'(MAX_IFACES);
  logic [2:0] iused;
  assign iused = (icount_r > MAXI) ? MAXI : icount_r;

  // Route table: valid bits in flops, the rest per slot registers read at
  // the scan index or at the hit slot.
  logic [TABLE_DEPTH-1:0] valid_r;
  logic [31:0] tgt_r  [TABLE_DEPTH];
  logic [31:0] hop_r  [TABLE_DEPTH];
  logic [31:0] prov_r [TABLE_DEPTH];
  logic [4:0]  met_r  [TABLE_DEPTH];
  logic [7:0]  miss_r [TABLE_DEPTH];

  // Captured word and scan state.
  logic [2:0]  act_r;
  logic [31:0] dest_r, hop_in_r, port_r, dnet_r;
  logic [4:0]  min_r;
  logic [IW-1:0] idx_r;
  logic [2:0]  ifx_r;
  logic        hit_r, free_r, local_r, ihit_r;
  logic [IW-1:0] hit_idx_r, free_idx_r;

  // Output register.
  logic        ov_r, olast_r, oen_r;
  logic [2:0]  ost_r;
  logic [31:0] onet_r;
  logic [4:0]  omet_r;

  // Emitted entries are held back by one so last can land on the final
  // one: the held word is presented only when its successor is known.
  logic        hv_r;
  logic [31:0] hnet_r;
  logic [4:0]  hmt_r;

  logic is_emit, horizon, sv;
  assign is_emit = act_r == ACT_DUMP || act_r == ACT_ADV;
  assign horizon = act_r == ACT_ADV && horizon_r != 2'd0;
  assign sv = valid_r[idx_r];

  assign sts.slot_done = idx_r == IW'(TABLE_DEPTH - 1);
  assign sts.if_done = !(is_emit || act_r == ACT_UPDATE || act_r == ACT_QUERY)
                       || ifx_r >= iused;
  assign sts.emit = ov_r;
  assign sts.act_tick = act_r == ACT_TICK;
  assign sts.act_bad = act_r > ACT_ADV;
  assign sts.act_emit = is_emit;

  logic [7:0] miss_inc;
  assign miss_inc = (miss_r[idx_r] == 8'hff) ? 8'hff : miss_r[idx_r] + 8'd1;

  // Does the current slot produce a word during dump or advertise?
  logic slot_out, slot_poison;
  assign slot_poison = horizon && prov_r[idx_r] == port_r;
  assign slot_out = is_emit && sv && (!slot_poison || horizon_r >= 2'd2);

  logic [31:0] ifa;
  assign ifa = iface_r[ifx_r[1:0]];
  logic if_out;
  assign if_out = is_emit && !(horizon && ifa == port_r);

  logic [4:0] hmet;
  assign hmet = hit_r ? met_r[hit_idx_r] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      ov_r <= 1'b0;
      hv_r <= 1'b0;
      act_r <= ACT_TICK;
    end else begin
      if (cmd.pop) ov_r <= 1'b0;
      if (cmd.load) begin
        act_r <= in_action;
        dest_r <= in_dest_addr;
        dnet_r <= class_net(in_dest_addr);
        hop_in_r <= in_sender_addr;
        port_r <= in_port_addr;
        min_r <= (in_metric_in > UNREACHABLE) ? UNREACHABLE : in_metric_in;
        idx_r <= '0;
        ifx_r <= '0;
        {hit_r, free_r, local_r, ihit_r} <= '0;
        hv_r <= 1'b0;
        hit_idx_r <= '0;
        free_idx_r <= '0;
      end
      if (cmd.slot_step) begin
        if (!sts.slot_done) idx_r <= idx_r + IW'(1);
        if (act_r == ACT_TICK && sv) begin
          miss_r[idx_r] <= miss_inc;
          if (miss_inc > discard_r) valid_r[idx_r] <= 1'b0;
          else if (miss_inc > far_r) met_r[idx_r] <= UNREACHABLE;
        end
        if (sv && !hit_r && class_net(tgt_r[idx_r]) == dnet_r) begin
          hit_r <= 1'b1;
          hit_idx_r <= idx_r;
        end
        if (!sv && !free_r) begin
          free_r <= 1'b1;
          free_idx_r <= idx_r;
        end
        if (slot_out) begin
          if (hv_r) begin
            ov_r <= 1'b1;
            ost_r <= ST_ENTRY;
            onet_r <= hnet_r;
            omet_r <= hmt_r;
            oen_r <= 1'b1;
            olast_r <= 1'b0;
          end
          hv_r <= 1'b1;
          hnet_r <= tgt_r[idx_r];
          hmt_r <= slot_poison ? UNREACHABLE : plus_one(met_r[idx_r]);
        end
      end
      if (cmd.if_step) begin
        ifx_r <= ifx_r + 3'd1;
        if (class_net(ifa) == dnet_r) local_r <= 1'b1;
        if (ifa == dest_r) ihit_r <= 1'b1;
        if (if_out) begin
          if (hv_r) begin
            ov_r <= 1'b1;
            ost_r <= ST_ENTRY;
            onet_r <= hnet_r;
            omet_r <= hmt_r;
            oen_r <= 1'b1;
            olast_r <= 1'b0;
          end
          hv_r <= 1'b1;
          hnet_r <= class_net(ifa);
          hmt_r <= METRIC_ONE;
        end
      end
      if (cmd.decide) begin
        // Final word of the item; for emission it is the held entry, or
        // an empty marker when nothing was sent.
        ov_r <= 1'b1;
        olast_r <= 1'b1;
        oen_r <= 1'b0;
        onet_r <= '0;
        omet_r <= '0;
        unique case (action_t'(act_r))
          ACT_UPDATE: begin
            if (hit_r) begin
              if (hop_r[hit_idx_r] == hop_in_r || hmet > min_r) begin
                ost_r <= ST_REPLACED;
                tgt_r[hit_idx_r] <= dest_r;
                hop_r[hit_idx_r] <= hop_in_r;
                prov_r[hit_idx_r] <= port_r;
                met_r[hit_idx_r] <= min_r;
                miss_r[hit_idx_r] <= '0;
              end else ost_r <= ST_IGNORED;
            end else if (local_r) ost_r <= ST_IGNORED;
            else if (free_r) begin
              ost_r <= ST_ADDED;
              valid_r[free_idx_r] <= 1'b1;
              tgt_r[free_idx_r] <= dest_r;
              hop_r[free_idx_r] <= hop_in_r;
              prov_r[free_idx_r] <= port_r;
              met_r[free_idx_r] <= min_r;
              miss_r[free_idx_r] <= '0;
            end else ost_r <= ST_FULL;
          end
          ACT_QUERY: begin
            if (hit_r) begin
              ost_r <= ST_HIT;
              onet_r <= tgt_r[hit_idx_r];
              omet_r <= plus_one(hmet);
              oen_r <= 1'b1;
            end else if (ihit_r) begin
              ost_r <= ST_HIT;
              onet_r <= dnet_r;
              omet_r <= METRIC_ONE;
              oen_r <= 1'b1;
            end else ost_r <= ST_MISS;
          end
          default: begin
            ost_r <= ST_ENTRY;
            if (hv_r) begin
              onet_r <= hnet_r;
              omet_r <= hmt_r;
              oen_r <= 1'b1;
              hv_r <= 1'b0;
            end
          end
        endcase
      end
    end
  end

  assign out_valid = ov_r;
  assign out_status = ost_r;
  assign out_net_addr = onet_r;
  assign out_metric = omet_r;
  assign out_entry_valid = oen_r;
  assign out_last = olast_r;

  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> ov_r) else $error("pop without word");
  a_last_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !oen_r) |-> olast_r) else $error("empty word not last");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !cmd.pop) |=> ov_r && $stable(onet_r)) else $error("word lost");

endmodule
